>>> rtl/core/lbba_pkg.sv
// ----------------------------------------------------------------------------
// Lookahead bitmap allocator package.
// Shared constants, operation and status codes and state types.
// ----------------------------------------------------------------------------
package lbba_pkg;

  // Bitmap word geometry.
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WORD_IDX_W = 6;

  // Default parameter values for the top level.
  localparam int unsigned MAX_WINDOW_WORDS_DEF = 8;
  localparam int unsigned BLOCK_ADDR_BITS_DEF  = 24;

  // Configuration register reset values and widths.
  localparam longint unsigned BLOCK_COUNT_RESET  = 64'd1024;
  localparam int unsigned     WINDOW_WORDS_W     = 4;
  localparam logic [WINDOW_WORDS_W-1:0] WINDOW_WORDS_RESET = 4'd8;

  // Depth of the command queue between front and back end.
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_ACK   = 2'd2,
    OP_DROP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_ALLOC     = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_SCAN      = 2'd2,
    STAT_ACCEPTED  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_BLOCK_COUNT  = 1'b0,
    CFG_WINDOW_WORDS = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MK_WS,
    BK_MK_BLK,
    BK_SCAN,
    BK_AL_WS,
    BK_AL_SUM,
    BK_EXH,
    BK_MV_WS,
    BK_MV_SUM,
    BK_RESP
  } back_state_e;

  typedef enum logic [1:0] {
    REM_IDLE,
    REM_CHECK,
    REM_ITER
  } rem_state_e;

endpackage

>>> rtl/core/lookahead_bitmap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Lookahead bitmap block allocator, top level.
// Ack and drop need no remainder pass; mark runs two, on the window start and
// then on the block number. Allocate scans the bitmap a word at a time, then runs
// two remainder passes for the hit or for a window move, unless no space is left.
// One word in service at a time; reset clears bitmap and window, countdown 1024.
// ----------------------------------------------------------------------------
module lookahead_bitmap_block_allocator_unit #(
  parameter int unsigned MAX_WINDOW_WORDS = lbba_pkg::MAX_WINDOW_WORDS_DEF,
  parameter int unsigned BLOCK_ADDR_BITS  = lbba_pkg::BLOCK_ADDR_BITS_DEF,
  localparam int unsigned WLEN_W = $clog2(lbba_pkg::WORD_BITS * MAX_WINDOW_WORDS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [BLOCK_ADDR_BITS-1:0] block_number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [BLOCK_ADDR_BITS-1:0] result_block_o,
  output logic [WLEN_W-1:0]          window_length_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [BLOCK_ADDR_BITS:0]   cfg_data_i
);
  import lbba_pkg::*;

  localparam int unsigned ABITS = BLOCK_ADDR_BITS;
  localparam int unsigned BC_W  = ABITS + 1;
  localparam int unsigned CMD_W = 2 + ABITS;
  localparam longint unsigned TOP_COUNT = 64'd1 << ABITS;
  localparam logic [BC_W-1:0] BC_TOP   = BC_W'(TOP_COUNT);
  localparam logic [BC_W-1:0] BC_RESET = BC_W'((BLOCK_COUNT_RESET > TOP_COUNT) ?
                                               TOP_COUNT : BLOCK_COUNT_RESET);

  logic [BC_W-1:0]           bc_q, bc_eff;
  logic [WINDOW_WORDS_W-1:0] words_q;
  logic [WLEN_W-1:0]         words_eff, cap;

  logic                      f_valid, f_ready;
  op_e                       f_op;
  logic [ABITS-1:0]          f_blk;
  logic                      q_valid, q_ready;
  logic [CMD_W-1:0]          q_data;
  status_e                   b_status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q    <= BC_RESET;
      words_q <= WINDOW_WORDS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BLOCK_COUNT:  bc_q    <= cfg_data_i;
        CFG_WINDOW_WORDS: words_q <= cfg_data_i[WINDOW_WORDS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective block count and window capacity.
  assign bc_eff = (bc_q < BC_W'(2)) ? BC_W'(2) : ((bc_q > BC_TOP) ? BC_TOP : bc_q);

  always_comb begin
    if (words_q == '0) begin
      words_eff = WLEN_W'(1);
    end else if (int'(words_q) > int'(MAX_WINDOW_WORDS)) begin
      words_eff = WLEN_W'(MAX_WINDOW_WORDS);
    end else begin
      words_eff = WLEN_W'(words_q);
    end
  end

  assign cap = words_eff << WORD_IDX_W;

  lbba_front #(
    .BLOCK_ADDR_BITS (ABITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .block_number_i (block_number_i),
    .push_valid_o   (f_valid),
    .push_ready_i   (f_ready),
    .push_op_o      (f_op),
    .push_blk_o     (f_blk)
  );

  lbba_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_op, f_blk}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  lbba_back #(
    .MAX_WINDOW_WORDS (MAX_WINDOW_WORDS),
    .BLOCK_ADDR_BITS  (ABITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_ready_o     (q_ready),
    .cmd_op_i        (op_e'(q_data[CMD_W-1:ABITS])),
    .cmd_blk_i       (q_data[ABITS-1:0]),
    .bc_i            (bc_eff),
    .cap_i           (cap),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (b_status),
    .result_block_o  (result_block_o),
    .window_length_o (window_length_o)
  );

  assign status_o = b_status;

  // Only a scan-needed word carries a window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_SCAN) |-> window_length_o == '0)
    else $error("window length set on a word other than scan needed");

  // A moved window is never empty, since the countdown was nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_SCAN) |-> window_length_o != '0)
    else $error("scan needed with an empty window");

  // No space and accepted words carry no block number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_ALLOC) && (status_o != STAT_SCAN)
      |-> result_block_o == '0)
    else $error("block number set on a word without a block");

endmodule

>>> rtl/core/lbba_front.sv
// ----------------------------------------------------------------------------
// Allocator front end.
// Accepts request words into a holding register, classifies the operation
// and drops the block number of every operation other than mark.
// ----------------------------------------------------------------------------
module lbba_front #(
  parameter int unsigned BLOCK_ADDR_BITS = lbba_pkg::BLOCK_ADDR_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [BLOCK_ADDR_BITS-1:0] block_number_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output lbba_pkg::op_e              push_op_o,
  output logic [BLOCK_ADDR_BITS-1:0] push_blk_o
);
  import lbba_pkg::*;

  logic                       hold_q;
  op_e                        op_q;
  logic [BLOCK_ADDR_BITS-1:0] blk_q;
  op_e                        op_in;

  assign op_in      = op_e'(op_i);
  assign in_ready_o = !hold_q || push_ready_i;

  // Holding register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_q <= in_valid_i;
    end
  end

  // Classified word; only a mark carries a block number.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_in;
      blk_q <= (op_in == OP_MARK) ? block_number_i : '0;
    end
  end

  assign push_valid_o = hold_q;
  assign push_op_o    = op_q;
  assign push_blk_o   = blk_q;

endmodule

>>> rtl/core/lbba_fifo.sv
// ----------------------------------------------------------------------------
// Allocator command queue.
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lbba_fifo #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = lbba_pkg::CMD_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import lbba_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/lbba_rem.sv
// ----------------------------------------------------------------------------
// Allocator remainder unit.
// Reduces a value modulo the block count, one quotient bit per cycle, with a
// fast exit when the value is already below the block count.
// ----------------------------------------------------------------------------
module lbba_rem #(
  parameter int unsigned NUM_W = 25,
  parameter int unsigned DEN_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [DEN_W-1:0] rem_o
);
  import lbba_pkg::*;

  localparam int unsigned CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  rem_state_e       state_q, state_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shifted;

  assign shifted = {r_q, num_q[NUM_W-1]};

  // Restoring remainder sequencer.
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      REM_IDLE: begin
        if (start_i) begin
          num_d   = num_i;
          state_d = REM_CHECK;
        end
      end
      REM_CHECK: begin
        if (CMP_W'(num_q) < CMP_W'(den_i)) begin
          r_d     = DEN_W'(num_q);
          done_d  = 1'b1;
          state_d = REM_IDLE;
        end else begin
          r_d     = '0;
          cnt_d   = CNT_W'(NUM_W);
          state_d = REM_ITER;
        end
      end
      REM_ITER: begin
        num_d = num_q << 1;
        if (shifted >= {1'b0, den_i}) begin
          r_d = DEN_W'(shifted - {1'b0, den_i});
        end else begin
          r_d = shifted[DEN_W-1:0];
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = REM_IDLE;
        end
      end
      default: begin
        state_d = REM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= REM_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

>>> rtl/core/lbba_back.sv
// ----------------------------------------------------------------------------
// Allocator back end.
// Executes one queued command at a time: bitmap marks, word-wise scans for
// the next clear bit, window moves and countdown updates.
// ----------------------------------------------------------------------------
module lbba_back #(
  parameter int unsigned MAX_WINDOW_WORDS = lbba_pkg::MAX_WINDOW_WORDS_DEF,
  parameter int unsigned BLOCK_ADDR_BITS  = lbba_pkg::BLOCK_ADDR_BITS_DEF,
  localparam int unsigned WLEN_W = $clog2(lbba_pkg::WORD_BITS * MAX_WINDOW_WORDS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  lbba_pkg::op_e              cmd_op_i,
  input  logic [BLOCK_ADDR_BITS-1:0] cmd_blk_i,
  input  logic [BLOCK_ADDR_BITS:0]   bc_i,
  input  logic [WLEN_W-1:0]          cap_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lbba_pkg::status_e          status_o,
  output logic [BLOCK_ADDR_BITS-1:0] result_block_o,
  output logic [WLEN_W-1:0]          window_length_o
);
  import lbba_pkg::*;

  localparam int unsigned ABITS  = BLOCK_ADDR_BITS;
  localparam int unsigned CD_W   = ABITS + 1;
  localparam int unsigned WIDX_W = (MAX_WINDOW_WORDS > 1) ? $clog2(MAX_WINDOW_WORDS) : 1;
  localparam int unsigned NUM_W  = ((ABITS > WLEN_W) ? ABITS : WLEN_W) + 1;
  localparam int unsigned OFF_W  = ((ABITS + 2) > WLEN_W) ? (ABITS + 2) : WLEN_W;
  localparam int unsigned SZ_W   = (CD_W > WLEN_W) ? CD_W : WLEN_W;
  localparam int unsigned STEP_W = WORD_IDX_W + 1;
  localparam longint unsigned TOP_COUNT = 64'd1 << ABITS;
  localparam logic [CD_W-1:0] CD_RESET = CD_W'((BLOCK_COUNT_RESET > TOP_COUNT) ?
                                               TOP_COUNT : BLOCK_COUNT_RESET);

  back_state_e           state_q, state_d;
  logic [WORD_BITS-1:0]  bitmap_q [MAX_WINDOW_WORDS];
  logic [WORD_BITS-1:0]  bitmap_d [MAX_WINDOW_WORDS];
  logic [ABITS-1:0]      ws_q, ws_d;
  logic [WLEN_W-1:0]     size_q, size_d;
  logic [WLEN_W-1:0]     pos_q, pos_d;
  logic [CD_W-1:0]       cd_q, cd_d;
  logic                  found_q, found_d;
  logic [WLEN_W-1:0]     off_q, off_d;
  logic [ABITS-1:0]      wsr_q, wsr_d;
  logic [ABITS-1:0]      blk_q, blk_d;

  // Pending result and output register.
  status_e               rstat_q, rstat_d;
  logic [ABITS-1:0]      rres_q, rres_d;
  logic [WLEN_W-1:0]     rlen_q, rlen_d;
  logic                  ov_q, ov_d;
  logic                  out_load;
  status_e               ostat_q;
  logic [ABITS-1:0]      ores_q;
  logic [WLEN_W-1:0]     olen_q;

  // Remainder unit interface.
  logic                  rem_start;
  logic [NUM_W-1:0]      rem_num;
  logic                  rem_done;
  logic [CD_W-1:0]       rem_val;

  // Scan datapath.
  logic [WIDX_W-1:0]     word_sel;
  logic [WORD_BITS-1:0]  cur_word;
  logic [WLEN_W-1:0]     wbase, wnext, wend, cand_pos, new_pos;
  logic [STEP_W-1:0]     lim, steps;
  logic [WORD_IDX_W-1:0] lo, hit_idx;
  logic [WORD_BITS-1:0]  cand_mask;
  logic                  hit;
  logic [CD_W-1:0]       cd_dec;

  // Mark and move datapath.
  logic [OFF_W-1:0]      mk_sum, mk_off;
  logic                  mk_hit;
  logic [WLEN_W-1:0]     new_size;

  lbba_rem #(
    .NUM_W (NUM_W),
    .DEN_W (CD_W)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .num_i   (rem_num),
    .den_i   (bc_i),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  // Current bitmap word and the clear-bit candidates inside the window.
  assign word_sel = pos_q[WORD_IDX_W +: WIDX_W];
  assign cur_word = bitmap_q[word_sel];
  assign wbase    = {pos_q[WLEN_W-1:WORD_IDX_W], {WORD_IDX_W{1'b0}}};
  assign wnext    = wbase + WLEN_W'(WORD_BITS);
  assign wend     = (wnext < size_q) ? wnext : size_q;
  assign lim      = STEP_W'(wend - wbase);
  assign lo       = pos_q[WORD_IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      cand_mask[i] = (STEP_W'(i) >= {1'b0, lo}) && (STEP_W'(i) < lim) && !cur_word[i];
    end
  end

  // Find the lowest candidate bit.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand_mask[i]) begin
        hit     = 1'b1;
        hit_idx = WORD_IDX_W'(i);
      end
    end
  end

  // During the skip phase the scan stops on a clear bit; otherwise it passes it.
  assign cand_pos = wbase + WLEN_W'(hit_idx);
  assign new_pos  = hit ? (found_q ? cand_pos : cand_pos + WLEN_W'(1)) : wend;
  assign steps    = STEP_W'(new_pos - pos_q);
  assign cd_dec   = (cd_q > CD_W'(steps)) ? cd_q - CD_W'(steps) : '0;

  // Mark offset: (block - start) modulo the block count, both already reduced.
  assign mk_sum   = OFF_W'(rem_val) + OFF_W'(bc_i) - OFF_W'(wsr_q);
  assign mk_off   = (mk_sum >= OFF_W'(bc_i)) ? mk_sum - OFF_W'(bc_i) : mk_sum;
  assign mk_hit   = mk_off < OFF_W'(size_q);

  // New window size after a move.
  assign new_size = (SZ_W'(cd_q) < SZ_W'(cap_i)) ? WLEN_W'(cd_q) : cap_i;

  assign out_load    = (state_q == BK_RESP) && (!ov_q || out_ready_i);
  assign cmd_ready_o = (state_q == BK_IDLE);

  // Command sequencer.
  always_comb begin
    state_d   = state_q;
    bitmap_d  = bitmap_q;
    ws_d      = ws_q;
    size_d    = size_q;
    pos_d     = pos_q;
    cd_d      = cd_q;
    found_d   = found_q;
    off_d     = off_q;
    wsr_d     = wsr_q;
    blk_d     = blk_q;
    rstat_d   = rstat_q;
    rres_d    = rres_q;
    rlen_d    = rlen_q;
    rem_start = 1'b0;
    rem_num   = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          blk_d   = cmd_blk_i;
          rstat_d = STAT_ACCEPTED;
          rres_d  = '0;
          rlen_d  = '0;
          case (cmd_op_i)
            OP_ALLOC: begin
              found_d = 1'b0;
              state_d = (pos_q < size_q) ? BK_SCAN : BK_EXH;
            end
            OP_MARK: begin
              rem_start = 1'b1;
              rem_num   = NUM_W'(ws_q);
              state_d   = BK_MK_WS;
            end
            OP_ACK: begin
              cd_d    = bc_i;
              state_d = BK_RESP;
            end
            OP_DROP: begin
              size_d  = '0;
              pos_d   = '0;
              cd_d    = bc_i;
              state_d = BK_RESP;
            end
            default: begin
              state_d = BK_RESP;
            end
          endcase
        end
      end
      BK_MK_WS: begin
        if (rem_done) begin
          wsr_d     = rem_val[ABITS-1:0];
          rem_start = 1'b1;
          rem_num   = NUM_W'(blk_q);
          state_d   = BK_MK_BLK;
        end
      end
      BK_MK_BLK: begin
        if (rem_done) begin
          if (mk_hit) begin
            bitmap_d[mk_off[WORD_IDX_W +: WIDX_W]][mk_off[WORD_IDX_W-1:0]] = 1'b1;
          end
          state_d = BK_RESP;
        end
      end
      BK_SCAN: begin
        pos_d = new_pos;
        cd_d  = cd_dec;
        if (hit && !found_q) begin
          off_d   = cand_pos;
          found_d = 1'b1;
        end
        if ((hit && found_q) || (new_pos >= size_q && (hit || found_q))) begin
          rem_start = 1'b1;
          rem_num   = NUM_W'(ws_q);
          state_d   = BK_AL_WS;
        end else if (new_pos >= size_q) begin
          state_d = BK_EXH;
        end
      end
      BK_AL_WS: begin
        if (rem_done) begin
          rem_start = 1'b1;
          rem_num   = NUM_W'(rem_val[ABITS-1:0]) + NUM_W'(off_q);
          state_d   = BK_AL_SUM;
        end
      end
      BK_AL_SUM: begin
        if (rem_done) begin
          rstat_d = STAT_ALLOC;
          rres_d  = rem_val[ABITS-1:0];
          state_d = BK_RESP;
        end
      end
      BK_EXH: begin
        if (cd_q == '0) begin
          rstat_d = STAT_NO_SPACE;
          state_d = BK_RESP;
        end else begin
          rem_start = 1'b1;
          rem_num   = NUM_W'(ws_q);
          state_d   = BK_MV_WS;
        end
      end
      BK_MV_WS: begin
        if (rem_done) begin
          rem_start = 1'b1;
          rem_num   = NUM_W'(rem_val[ABITS-1:0]) + NUM_W'(size_q);
          state_d   = BK_MV_SUM;
        end
      end
      BK_MV_SUM: begin
        if (rem_done) begin
          ws_d    = rem_val[ABITS-1:0];
          size_d  = new_size;
          pos_d   = '0;
          for (int w = 0; w < MAX_WINDOW_WORDS; w++) begin
            bitmap_d[w] = '0;
          end
          rstat_d = STAT_SCAN;
          rres_d  = rem_val[ABITS-1:0];
          rlen_d  = new_size;
          state_d = BK_RESP;
        end
      end
      BK_RESP: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    ov_d = ov_q && !out_ready_i;
    if (out_load) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      for (int w = 0; w < MAX_WINDOW_WORDS; w++) begin
        bitmap_q[w] <= '0;
      end
      ws_q    <= '0;
      size_q  <= '0;
      pos_q   <= '0;
      cd_q    <= CD_RESET;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      bitmap_q <= bitmap_d;
      ws_q     <= ws_d;
      size_q   <= size_d;
      pos_q    <= pos_d;
      cd_q     <= cd_d;
      found_q  <= found_d;
      ov_q     <= ov_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    wsr_q   <= wsr_d;
    blk_q   <= blk_d;
    rstat_q <= rstat_d;
    rres_q  <= rres_d;
    rlen_q  <= rlen_d;
    if (out_load) begin
      ostat_q <= rstat_q;
      ores_q  <= rres_q;
      olen_q  <= rlen_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ostat_q;
  assign result_block_o  = ores_q;
  assign window_length_o = olen_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead bitmap block allocator testbench.
// A shadow of the allocator predicts one result word per accepted input word
// and checks every result word in order. Sender gaps and receiver stalls
// vary by phase, and the configuration registers change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import lbba_pkg::*;

  localparam int unsigned ADDR_W = BLOCK_ADDR_BITS_DEF;
  localparam int unsigned LEN_W  = $clog2(WORD_BITS * MAX_WINDOW_WORDS_DEF + 1);
  localparam longint unsigned ADDR_SPAN = 64'd1 << ADDR_W;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] blk;
    logic [LEN_W-1:0]  len;
  } alloc_word_t;

  // Shadow copy of the allocator state and the queue of predicted words.
  class alloc_shadow;
    bit [ADDR_W:0]        count_reg;
    bit [3:0]             words_reg;
    bit [WORD_BITS-1:0]   used_map [MAX_WINDOW_WORDS_DEF];
    bit [ADDR_W-1:0]      win_start;
    bit [LEN_W-1:0]       win_size;
    bit [LEN_W-1:0]       scan_pos;
    bit [ADDR_W:0]        countdown;
    status_e              last_status;
    alloc_word_t          pending_words[$];
    int unsigned          errors;

    function new();
      count_reg = (ADDR_W + 1)'(BLOCK_COUNT_RESET);
      words_reg = WINDOW_WORDS_RESET;
      foreach (used_map[i]) used_map[i] = '0;
      win_start = '0;
      win_size = '0;
      scan_pos = '0;
      countdown = (ADDR_W + 1)'(BLOCK_COUNT_RESET);
      last_status = STAT_ACCEPTED;
      errors = 0;
    endfunction

    function longint unsigned eff_count();
      if (count_reg < 2) return 2;
      if (longint'(count_reg) > ADDR_SPAN) return ADDR_SPAN;
      return longint'(count_reg);
    endfunction

    function longint unsigned eff_words();
      if (words_reg == 0) return 1;
      if (words_reg > MAX_WINDOW_WORDS_DEF) return MAX_WINDOW_WORDS_DEF;
      return longint'(words_reg);
    endfunction

    function bit is_used(longint unsigned pos);
      return used_map[(pos / WORD_BITS) % MAX_WINDOW_WORDS_DEF][pos % WORD_BITS];
    endfunction

    // One scan step: the position moves on and the countdown saturates at zero.
    function void advance();
      scan_pos = scan_pos + 1'b1;
      if (countdown != 0) countdown = countdown - 1'b1;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [ADDR_W:0] value);
      if (idx == CFG_BLOCK_COUNT) count_reg = value;
      else words_reg = value[3:0];
    endfunction

    // Predict the result word of one accepted input word.
    function void predict_word(op_e op, bit [ADDR_W-1:0] blk);
      longint unsigned bc, base, off, cap;
      alloc_word_t     res;
      bit              found;
      bc = eff_count();
      base = longint'(win_start) % bc;
      res.status = STAT_ACCEPTED;
      res.blk = '0;
      res.len = '0;
      case (op)
        OP_ALLOC: begin
          found = 1'b0;
          while (!found && scan_pos < win_size) begin
            off = longint'(scan_pos);
            advance();
            if (!is_used(off)) begin
              res.status = STAT_ALLOC;
              res.blk = ADDR_W'((base + off) % bc);
              // Skip the run of used blocks that follows the hit.
              while (scan_pos < win_size && is_used(longint'(scan_pos))) advance();
              found = 1'b1;
            end
          end
          if (!found) begin
            if (countdown == 0) begin
              res.status = STAT_NO_SPACE;
            end else begin
              // Move the window on and start a fresh bitmap.
              cap = WORD_BITS * eff_words();
              win_start = ADDR_W'((base + longint'(win_size)) % bc);
              win_size = (longint'(countdown) < cap) ? LEN_W'(countdown) : LEN_W'(cap);
              scan_pos = '0;
              foreach (used_map[i]) used_map[i] = '0;
              res.status = STAT_SCAN;
              res.blk = win_start;
              res.len = win_size;
            end
          end
        end
        OP_MARK: begin
          off = ((longint'(blk) % bc) + bc - base) % bc;
          if (off < longint'(win_size))
            used_map[(off / WORD_BITS) % MAX_WINDOW_WORDS_DEF][off % WORD_BITS] = 1'b1;
        end
        OP_ACK: begin
          countdown = (ADDR_W + 1)'(bc);
        end
        default: begin
          win_size = '0;
          scan_pos = '0;
          countdown = (ADDR_W + 1)'(bc);
        end
      endcase
      pending_words.push_back(res);
      last_status = res.status;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result word with the oldest prediction.
    task check_word(logic [1:0] st, logic [ADDR_W-1:0] blk, logic [LEN_W-1:0] len);
      alloc_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word status=%0d block=%0d len=%0d", st, blk, len));
      end else begin
        want = pending_words.pop_front();
        if (st !== want.status)
          report($sformatf("status %0d, want %0d", st, want.status));
        if (blk !== want.blk)
          report($sformatf("result_block %0d, want %0d", blk, want.blk));
        if (len !== want.len)
          report($sformatf("window_length %0d, want %0d", len, want.len));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        op_i;
  logic [ADDR_W-1:0] block_number_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] result_block_o;
  logic [LEN_W-1:0]  window_length_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic [ADDR_W:0]   cfg_data_i;

  alloc_shadow shadow = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Register settings per random phase, extremes included.
  bit [ADDR_W:0] count_plan [8] = '{25'd1000, 25'd0, 25'd37, 25'h1000000,
                                    25'd700, 25'h1FFFFFF, 25'd200, 25'd129};
  bit [3:0]      words_plan [8] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd9, 4'd8, 4'd2, 4'd4};

  lookahead_bitmap_block_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_block_o (result_block_o),
    .window_length_o(window_length_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result words are checked as they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      shadow.check_word(status_o, result_block_o, window_length_o);
  end

  // Send one input word, with random idle cycles ahead of it.
  task send_word(op_e op, bit [ADDR_W-1:0] blk);
    int unsigned gaps;
    gaps = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gaps++;
    if (gaps != 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    block_number_i <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.predict_word(op, blk);
    @(negedge clk_i);
  endtask

  task write_reg(cfg_reg_e idx, bit [ADDR_W:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until every predicted word has come back, then let the block settle.
  task drain();
    in_valid_i <= 1'b0;
    while (shadow.pending_words.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Block number at a window offset, sometimes given as an alias above the count.
  function automatic bit [ADDR_W-1:0] window_block(longint unsigned off);
    longint unsigned bc, b;
    bc = shadow.eff_count();
    b = ((longint'(shadow.win_start) % bc) + off) % bc;
    if ($urandom_range(0, 4) == 0 && b + bc < ADDR_SPAN) b = b + bc;
    return ADDR_W'(b);
  endfunction

  function automatic longint unsigned any_offset();
    if (shadow.win_size == 0) return $urandom_range(0, 63);
    return $urandom_range(0, int'(shadow.win_size) - 1);
  endfunction

  // Mostly allocate-and-mark traffic, with acks, drops and stray marks mixed in.
  task run_random(int unsigned count);
    int unsigned     sent;
    int unsigned     pick;
    int unsigned     burst;
    longint unsigned off;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(OP_ALLOC, ADDR_W'($urandom()));
        sent++;
        // A new window wants its used blocks reported, often in runs.
        if (shadow.last_status == STAT_SCAN) begin
          burst = $urandom_range(0, 24);
          off = any_offset();
          repeat (burst) begin
            if ($urandom_range(0, 2) == 0) off = any_offset();
            else off = (off + 1) % longint'(shadow.win_size);
            send_word(OP_MARK, window_block(off));
          end
          sent += burst;
        end
      end else if (pick < 70) begin
        send_word(OP_MARK, window_block(any_offset()));
        sent++;
      end else if (pick < 80) begin
        send_word(OP_MARK, ADDR_W'($urandom()));
        sent++;
      end else if (pick < 88) begin
        // Marks on and just past the window edges.
        case ($urandom_range(0, 3))
          0: off = 0;
          1: off = (shadow.win_size == 0) ? 0 : longint'(shadow.win_size) - 1;
          2: off = longint'(shadow.win_size);
          default: off = shadow.eff_count() - 1;
        endcase
        send_word(OP_MARK, window_block(off));
        sent++;
      end else if (pick < 96) begin
        send_word(OP_ACK, ADDR_W'($urandom()));
        sent++;
      end else begin
        send_word(OP_DROP, ADDR_W'($urandom()));
        sent++;
      end
    end
  endtask

  // Watchdog.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_ALLOC;
    block_number_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BLOCK_COUNT;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: mark with no window, first window, used runs, aliases.
    send_word(OP_MARK, 24'd5);
    send_word(OP_ALLOC, 24'hFFFFFF);
    send_word(OP_MARK, 24'd0);
    send_word(OP_MARK, 24'd1);
    send_word(OP_MARK, 24'd3);
    send_word(OP_MARK, 24'd511);
    send_word(OP_MARK, 24'd512);
    send_word(OP_MARK, 24'hFFFFFF);
    send_word(OP_MARK, 24'd64);
    send_word(OP_MARK, 24'd65);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_ACK, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_DROP, 24'hFFFFFF);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    drain();

    // Count below the minimum and zero words: run the countdown out.
    write_reg(CFG_BLOCK_COUNT, 25'd1);
    write_reg(CFG_WINDOW_WORDS, 25'd0);
    send_word(OP_DROP, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    send_word(OP_MARK, 24'd1);
    send_word(OP_ACK, 24'd0);
    send_word(OP_ALLOC, 24'd0);
    drain();

    // Random phases, each with its own settings and idle pattern.
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BLOCK_COUNT, count_plan[p]);
      write_reg(CFG_WINDOW_WORDS, {21'd0, words_plan[p]});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      run_random(235);
      drain();
    end

    if (shadow.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
